// File: design/gpfu_pkg.sv
// Shared constants, fixed-point helpers and widths for the Gaussian pair generator.
// No dependencies.
package gpfu_pkg;

    localparam int UNIFORM_BITS_DEF = 24;
    localparam int CODE_W           = 24;
    localparam int SAMPLE_W         = 32;
    localparam int MEAN_W           = 32;
    localparam int SCALE_W          = 24;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    // register indexes (decoded from paddr[2])
    localparam logic REG_MEAN  = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    localparam int LOG_FRAC_BITS = 24;
    localparam logic [30:0] Q30_ONE     = 31'd1073741824;
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // floor(x/d) = (x*M) >> S for any 31-bit x, M = ceil(2^S/d), S = 31+ceil(log2 d)
    localparam int DIV_S42 = 37;
    localparam int DIV_S56 = 37;
    localparam int DIV_S20 = 36;
    localparam int DIV_S30 = 36;
    localparam int DIV_S6  = 34;
    localparam int DIV_S12 = 35;
    localparam logic [31:0] DIV_M42 = 32'(((64'd1 << DIV_S42) + 64'd41) / 64'd42);
    localparam logic [31:0] DIV_M56 = 32'(((64'd1 << DIV_S56) + 64'd55) / 64'd56);
    localparam logic [31:0] DIV_M20 = 32'(((64'd1 << DIV_S20) + 64'd19) / 64'd20);
    localparam logic [31:0] DIV_M30 = 32'(((64'd1 << DIV_S30) + 64'd29) / 64'd30);
    localparam logic [31:0] DIV_M6  = 32'(((64'd1 << DIV_S6) + 64'd5) / 64'd6);
    localparam logic [31:0] DIV_M12 = 32'(((64'd1 << DIV_S12) + 64'd11) / 64'd12);

    function automatic logic [30:0] div_recip(input logic [30:0] x, input logic [31:0] m,
                                              input int s);
        logic [62:0] prod;
        prod = 63'(x) * 63'(m);
        return 31'(prod >> s);
    endfunction

endpackage

// File: design/gpfu_if.sv
// Valid/ready channel interfaces for the Gaussian pair generator.
// Depends on gpfu_pkg.
interface gpfu_in_if import gpfu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] radius_uniform;
    logic [CODE_W-1:0] angle_uniform;

    modport source (output valid, radius_uniform, angle_uniform, input ready);
    modport sink   (input valid, radius_uniform, angle_uniform, output ready);
endinterface

interface gpfu_out_if import gpfu_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] cos_sample;
    logic signed [SAMPLE_W-1:0] sin_sample;

    modport source (output valid, cos_sample, sin_sample, input ready);
    modport sink   (input valid, cos_sample, sin_sample, output ready);
endinterface

// File: design/gaussian_pair_from_uniforms_core.sv
// Box-Muller Gaussian pair generator, fully pipelined, with APB config registers.
// Depends on gpfu_pkg and the channel interfaces in gpfu_if.sv.
// 55 register stages. One request per cycle unless the output stalls; the rate is
// set by the pipeline: 24 log2 squaring stages and 24 square-root stages each hold one
// step; the whole pipe advances together when the output register is free or its
// sample is taken. Reset (rst_n low, async): pipeline emptied,
// mean_offset = 0, std_scale = 1.0 (65536).
module gaussian_pair_from_uniforms_core
    import gpfu_pkg::*;
#(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gpfu_in_if.sink               sample_in,
    gpfu_out_if.source            sample_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // code bits that survive masking
    localparam int CW      = (UNIFORM_BITS < CODE_W) ? UNIFORM_BITS : CODE_W;
    localparam int SQ_N    = LOG_FRAC_BITS;     // squaring steps
    localparam int RT_N    = 24;                // sqrt result bits
    localparam int ST_M    = 1;                 // m, exponent
    localparam int ST_NORM = 2;                 // mantissa in Q1.30
    localparam int ST_SQ0  = 3;
    localparam int ST_L    = ST_SQ0 + SQ_N;     // -log2(u1) in Q.24
    localparam int ST_V    = ST_L + 1;          // -2 ln u1 in Q.40
    localparam int ST_RT0  = ST_V + 1;
    localparam int ST_G    = ST_RT0 + RT_N;     // sigma*r
    localparam int ST_MAG  = ST_G + 1;
    localparam int NS      = ST_MAG + 1;        // output register
    localparam int ST_T1   = ST_G - 10;         // first angle stage
    localparam int ANG_DLY = ST_T1 - 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MEAN_W-1:0]  mean_offset_reg;
    logic [SCALE_W-1:0] std_scale_reg;
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_offset_reg <= '0;
            std_scale_reg   <= SCALE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MEAN:  mean_offset_reg <= pwdata;
                REG_SCALE: std_scale_reg   <= pwdata[SCALE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MEAN:  prdata = mean_offset_reg;
            REG_SCALE: prdata = APB_DATA_W'(std_scale_reg);
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves when the output register is free
    // ------------------------------------------------------------------
    logic          en;
    logic [NS:1]   vld_reg;

    assign en               = !vld_reg[NS] || sample_out.ready;
    assign sample_in.ready  = en;
    assign sample_out.valid = vld_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-1:1], sample_in.valid};
    end

    // ------------------------------------------------------------------
    // Radius path: log2 by squaring
    // ------------------------------------------------------------------
    logic [CW:0]   m_reg;
    logic [4:0]    e_next;
    logic [30:0]   norm_x_reg;
    logic [5:0]    norm_ip_reg;
    logic [CODE_W-1:0] ang_reg [1:ANG_DLY];

    // exponent of m, taken in the same stage that normalizes it
    always_comb
    begin
        e_next = '0;
        for (int i = 0; i <= CW; i++)
        begin
            if (m_reg[i])
                e_next = 5'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg       <= {1'b0, sample_in.radius_uniform[CW-1:0]} + (CW+1)'(1);
            norm_x_reg  <= 31'(32'(m_reg) << (5'd30 - e_next));
            norm_ip_reg <= 6'(UNIFORM_BITS) - 6'(e_next);
            ang_reg[1]  <= sample_in.angle_uniform;
            for (int i = 2; i <= ANG_DLY; i++)
                ang_reg[i] <= ang_reg[i-1];
        end
    end

    logic [30:0]              sq_x_reg  [0:SQ_N-1];
    logic [LOG_FRAC_BITS-1:0] sq_f_reg  [0:SQ_N-1];
    logic [5:0]               sq_ip_reg [0:SQ_N-1];

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sq
        logic [30:0]              x_in;
        logic [LOG_FRAC_BITS-1:0] f_in;
        logic [5:0]               ip_in;
        logic [61:0]              prod;
        logic [31:0]              sq;

        if (k == 0)
        begin : g_first
            assign x_in  = norm_x_reg;
            assign f_in  = '0;
            assign ip_in = norm_ip_reg;
        end
        else
        begin : g_rest
            assign x_in  = sq_x_reg[k-1];
            assign f_in  = sq_f_reg[k-1];
            assign ip_in = sq_ip_reg[k-1];
        end

        assign prod = 62'(x_in) * 62'(x_in);
        assign sq   = prod[61:30];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_x_reg[k]  <= sq[31] ? sq[31:1] : sq[30:0];
                sq_f_reg[k]  <= {f_in[LOG_FRAC_BITS-2:0], sq[31]};
                sq_ip_reg[k] <= ip_in;
            end
        end
    end

    logic [29:0] l_reg;
    logic [60:0] v_prod;
    logic [46:0] v_reg;

    assign v_prod = 61'(l_reg) * 61'(TWO_LN2_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg <= 30'({sq_ip_reg[SQ_N-1], 24'd0}) - 30'(sq_f_reg[SQ_N-1]);
            v_reg <= v_prod[60:14];
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage
    // ------------------------------------------------------------------
    logic [47:0] rt_rem_reg [0:RT_N-1];
    logic [47:0] rt_r_reg   [0:RT_N-1];

    for (genvar j = 0; j < RT_N; j++)
    begin : g_rt
        localparam int BP = 2*(RT_N-1) - 2*j;
        logic [47:0] rem_in;
        logic [47:0] r_in;
        logic [47:0] trial;

        if (j == 0)
        begin : g_first
            assign rem_in = 48'(v_reg);
            assign r_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rt_rem_reg[j-1];
            assign r_in   = rt_r_reg[j-1];
        end

        assign trial = r_in + (48'd1 << BP);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rt_rem_reg[j] <= rem_in - trial;
                    rt_r_reg[j]   <= (r_in >> 1) + (48'd1 << BP);
                end
                else
                begin
                    rt_rem_reg[j] <= rem_in;
                    rt_r_reg[j]   <= r_in >> 1;
                end
            end
        end
    end

    logic [47:0] g_prod;
    logic [31:0] g_reg;

    assign g_prod = 48'(std_scale_reg) * 48'(rt_r_reg[RT_N-1][23:0]);

    always_ff @(posedge clk)
    begin
        if (en)
            g_reg <= g_prod[47:16];
    end

    // ------------------------------------------------------------------
    // Angle path: quadrant fold, then sin/cos polynomials in Q.30
    // ------------------------------------------------------------------
    logic [CW-1:0] ang_code;
    logic [31:0]   phase;
    logic [1:0]    quad_reg [1:10];
    logic          lo_reg   [1:10];
    logic [30:0]   d_reg;
    logic [29:0]   t_reg    [2:8];
    logic [29:0]   t2_reg   [3:8];
    logic [30:0]   ws1_reg, wc1_reg, ws2_reg, wc2_reg, ws3_reg, wc3_reg;
    logic [29:0]   ps5_reg, pc5_reg, ps7_reg, pc7_reg, pc9_reg;
    logic [29:0]   s9_reg, s10_reg;
    logic [30:0]   c10_reg;
    logic [61:0]   t_prod, t2_prod;
    logic [60:0]   ps5_prod, pc5_prod, ps7_prod, pc7_prod, s9_prod, pc9_prod;
    logic [30:0]   c0, s0;
    logic [30:0]   cm_reg, sm_reg;
    logic          cneg_reg, sneg_reg;

    assign ang_code = ang_reg[ANG_DLY][CW-1:0];
    assign phase    = 32'(ang_code) << (32 - UNIFORM_BITS);
    assign t_prod   = 62'(d_reg) * 62'(HALF_PI_Q30);
    assign t2_prod  = 62'(t_reg[2]) * 62'(t_reg[2]);
    assign ps5_prod = 61'(t2_reg[4]) * 61'(ws1_reg);
    assign pc5_prod = 61'(t2_reg[4]) * 61'(wc1_reg);
    assign ps7_prod = 61'(t2_reg[6]) * 61'(ws2_reg);
    assign pc7_prod = 61'(t2_reg[6]) * 61'(wc2_reg);
    assign s9_prod  = 61'(t_reg[8]) * 61'(ws3_reg);
    assign pc9_prod = 61'(t2_reg[8]) * 61'(wc3_reg);
    assign c0       = lo_reg[10] ? c10_reg : 31'(s10_reg);
    assign s0       = lo_reg[10] ? 31'(s10_reg) : c10_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // first angle stage
            quad_reg[1] <= phase[31:30];
            lo_reg[1]   <= !phase[29];
            d_reg       <= phase[29] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
            for (int i = 2; i <= 10; i++)
            begin
                quad_reg[i] <= quad_reg[i-1];
                lo_reg[i]   <= lo_reg[i-1];
            end
            t_reg[2] <= t_prod[59:30];
            for (int i = 3; i <= 8; i++)
                t_reg[i] <= t_reg[i-1];
            t2_reg[3] <= t2_prod[59:30];
            for (int i = 4; i <= 8; i++)
                t2_reg[i] <= t2_reg[i-1];

            ws1_reg <= Q30_ONE - div_recip(31'(t2_reg[3]), DIV_M42, DIV_S42);
            wc1_reg <= Q30_ONE - div_recip(31'(t2_reg[3]), DIV_M56, DIV_S56);
            ps5_reg <= ps5_prod[59:30];
            pc5_reg <= pc5_prod[59:30];
            ws2_reg <= Q30_ONE - div_recip(31'(ps5_reg), DIV_M20, DIV_S20);
            wc2_reg <= Q30_ONE - div_recip(31'(pc5_reg), DIV_M30, DIV_S30);
            ps7_reg <= ps7_prod[59:30];
            pc7_reg <= pc7_prod[59:30];
            ws3_reg <= Q30_ONE - div_recip(31'(ps7_reg), DIV_M6, DIV_S6);
            wc3_reg <= Q30_ONE - div_recip(31'(pc7_reg), DIV_M12, DIV_S12);
            s9_reg  <= s9_prod[59:30];
            pc9_reg <= pc9_prod[59:30];
            s10_reg <= s9_reg;
            c10_reg <= Q30_ONE - 31'(pc9_reg >> 1);

            // quadrant mapping
            case (quad_reg[10])
                2'd0:    begin cm_reg <= c0; cneg_reg <= 1'b0; sm_reg <= s0; sneg_reg <= 1'b0; end
                2'd1:    begin cm_reg <= s0; cneg_reg <= 1'b1; sm_reg <= c0; sneg_reg <= 1'b0; end
                2'd2:    begin cm_reg <= c0; cneg_reg <= 1'b1; sm_reg <= s0; sneg_reg <= 1'b1; end
                default: begin cm_reg <= s0; cneg_reg <= 1'b0; sm_reg <= c0; sneg_reg <= 1'b1; end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Scale, round, offset and saturate
    // ------------------------------------------------------------------
    logic [63:0] mc_prod, ms_prod;
    logic [29:0] mag_c_reg, mag_s_reg;
    logic        cneg_m_reg, sneg_m_reg;
    logic signed [33:0] y_c, y_s, mu_x;
    logic signed [SAMPLE_W-1:0] cos_reg, sin_reg;

    assign mc_prod = 64'(g_reg) * 64'(cm_reg) + (64'd1 << 33);
    assign ms_prod = 64'(g_reg) * 64'(sm_reg) + (64'd1 << 33);
    assign mu_x    = 34'(signed'(mean_offset_reg));
    assign y_c     = cneg_m_reg ? mu_x - 34'(mag_c_reg) : mu_x + 34'(mag_c_reg);
    assign y_s     = sneg_m_reg ? mu_x - 34'(mag_s_reg) : mu_x + 34'(mag_s_reg);

    function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [33:0] y);
        if (y > 34'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (y < -34'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return y[SAMPLE_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_c_reg  <= mc_prod[63:34];
            mag_s_reg  <= ms_prod[63:34];
            cneg_m_reg <= cneg_reg;
            sneg_m_reg <= sneg_reg;
            cos_reg    <= sat32(y_c);
            sin_reg    <= sat32(y_s);
        end
    end

    assign sample_out.cos_sample = cos_reg;
    assign sample_out.sin_sample = sin_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_SQ0+SQ_N-1] |-> sq_x_reg[SQ_N-1][30])
        else $error("log mantissa left [1,2)");

    a_trig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_G] |-> (cm_reg <= Q30_ONE) && (sm_reg <= Q30_ONE))
        else $error("trig magnitude above one");

    a_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[ST_MAG] && mag_c_reg == '0 && mag_s_reg == '0
        |=> cos_reg == sin_reg)
        else $error("zero radius gave unequal samples");

endmodule
